[rtl/apq_pkg.sv]
// Shared types and codes for the array priority queue.
package apq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_PEEK   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_START,
    S_SHIFT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [15:0] prio;
    logic [31:0] elem;
  } entry_t;

  typedef struct packed {
    logic    st_load;
    status_t st_code;
    logic    ins_write;
    logic    scan_begin;
    logic    scan_step;
    logic    shift_begin;
    logic    shift_step;
    logic    dec_count;
    logic    resp_load;
  } apq_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic scan_last;
    logic best_last;
    logic out_busy;
  } apq_stat_t;

endpackage

[rtl/apq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module apq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/apq_ctrl.sv]
// Controller state machine for the array priority queue.
module apq_ctrl
  import apq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic [1:0] s_tuser,
  input  apq_stat_t stat,
  output apq_cmd_t  cmd
);

  state_t state, state_next;
  logic   remove_op, remove_op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      remove_op <= 1'b0;
    end else begin
      state     <= state_next;
      remove_op <= remove_op_next;
    end
  end

  always_comb begin
    state_next     = state;
    remove_op_next = remove_op;
    cmd            = '0;
    cmd.st_code    = STAT_OK;
    s_tready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.st_load    = 1'b1;
          remove_op_next = (kind_t'(s_tuser) == KIND_REMOVE);
          state_next     = S_RESP;
          unique case (kind_t'(s_tuser))
            KIND_INSERT: begin
              if (stat.count_full) begin
                cmd.st_code = STAT_FULL;
              end else begin
                cmd.ins_write = 1'b1;
              end
            end
            KIND_PEEK, KIND_REMOVE: begin
              if (stat.count_zero) begin
                cmd.st_code = STAT_EMPTY;
              end else begin
                cmd.scan_begin = 1'b1;
                state_next     = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = remove_op ? S_SHIFT_START : S_RESP;
        end
      end
      S_SHIFT_START: begin
        if (stat.best_last) begin
          cmd.dec_count = 1'b1;
          state_next    = S_RESP;
        end else begin
          cmd.shift_begin = 1'b1;
          state_next      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.scan_last) begin
          cmd.dec_count = 1'b1;
          state_next    = S_RESP;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/apq_dp.sv]
// Datapath: entry store, scan compare, shift pointer, result register.
module apq_dp
  import apq_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [47:0] s_tdata,
  input  apq_cmd_t    cmd,
  output apq_stat_t   stat,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  output logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic [AW-1:0] ptr;
  logic [AW-1:0] best_idx;
  entry_t        best;
  logic          serve_smallest;
  logic          found;
  status_t       res_status;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rdata;
  logic          better;
  logic [CW-1:0] last_idx;

  logic [31:0]   out_elem;
  logic [15:0]   out_prio;
  logic [3:0]    out_occ;
  status_t       out_status;

  apq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cfg_ready = 1'b1;
  assign last_idx  = count - CW'(1);

  always_comb begin
    we    = cmd.ins_write | cmd.shift_step;
    waddr = cmd.ins_write ? count[AW-1:0] : (ptr - AW'(1));
    wdata = cmd.ins_write ? entry_t'(s_tdata) : rdata;
    priority if (cmd.scan_begin) begin
      raddr = '0;
    end else if (cmd.shift_begin) begin
      raddr = best_idx + AW'(1);
    end else begin
      raddr = ptr + AW'(1);
    end
    better = serve_smallest ? (rdata.prio < best.prio) : (rdata.prio > best.prio);
  end

  assign stat.count_zero = (count == '0);
  assign stat.count_full = (count == CW'(CAPACITY));
  assign stat.scan_last  = (CW'(ptr) == last_idx);
  assign stat.best_last  = (CW'(best_idx) == last_idx);
  assign stat.out_busy   = m_tvalid & ~m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      serve_smallest <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        serve_smallest <= cfg_data;
      end
      if (cmd.ins_write) begin
        count <= count + CW'(1);
      end else if (cmd.dec_count) begin
        count <= count - CW'(1);
      end
      if (cmd.resp_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.st_load) begin
      res_status <= cmd.st_code;
      found      <= cmd.scan_begin;
    end
    if (cmd.scan_begin || cmd.shift_begin || cmd.scan_step || cmd.shift_step) begin
      ptr <= raddr;
    end
    if (cmd.scan_step && ((ptr == '0) || better)) begin
      best     <= rdata;
      best_idx <= ptr;
    end
    if (cmd.resp_load) begin
      out_status <= res_status;
      out_elem   <= found ? best.elem : 32'd0;
      out_prio   <= found ? best.prio : 16'd0;
      out_occ    <= 4'(count);
    end
  end

  assign m_tdata = {4'd0, out_occ, out_prio, out_elem};
  assign m_tuser = out_status;

endmodule

[rtl/array_priority_queue.sv]
// Top level of the array priority queue: controller, datapath and port wiring.
// An insert, a rejected operation or an unused kind goes from accept straight
// to the result without a search. A peek reads every stored entry, and a
// remove then also shifts down the entries after the one it found: the entry
// RAM has one read port, so the search reads one entry a cycle and the shift
// after a remove moves one entry a cycle. The next item is taken once the
// result is in the output register, even while it still waits to be taken.
module array_priority_queue
  import apq_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // element_value[31:0], priority_value[47:32]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // found_element[31:0], found_priority[47:32],
                                 // occupancy[51:48], zero[55:52]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // serve_smallest
);

  apq_cmd_t  cmd;
  apq_stat_t stat;

  apq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  apq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule
